>>> rtl/gcrf_pkg.sv
package gcrf_pkg;

	localparam int LAT_W      = 24;
	localparam int LON_W      = 25;
	localparam int RANGE_W    = 14;
	localparam int DIST_W     = 22;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 25;
	localparam int ANG_W      = 26;
	localparam int COS_W      = 32;
	localparam int HAV_W      = 31;
	localparam int ROOT_W     = 31;
	localparam int Z_W        = 23;
	localparam int STEPS      = 23;
	localparam int SQRT_STEPS = 31;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_LAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_LON  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MILES = 2'd2;

	localparam logic signed [32:0] CORDIC_K  = 33'sd652032874;
	localparam logic signed [32:0] Q_ONE     = 33'sd1073741824;
	localparam logic [26:0]        TURN_Q16  = 27'd23592960;
	localparam logic [26:0]        HALF_Q16  = 27'd11796480;
	localparam logic [26:0]        QUART_Q16 = 27'd5898240;
	localparam logic [23:0]        DIST_SCALE = 24'd9056759;
	localparam logic [DIST_W-1:0]  DIST_MAX  = 22'd3183872;

	function automatic logic [Z_W-1:0] atan_q16(input int i);
		case (i)
			0:  return 23'd2949120;
			1:  return 23'd1740967;
			2:  return 23'd919879;
			3:  return 23'd466945;
			4:  return 23'd234379;
			5:  return 23'd117305;
			6:  return 23'd58666;
			7:  return 23'd29335;
			8:  return 23'd14668;
			9:  return 23'd7334;
			10: return 23'd3667;
			11: return 23'd1833;
			12: return 23'd917;
			13: return 23'd458;
			14: return 23'd229;
			15: return 23'd115;
			16: return 23'd57;
			17: return 23'd29;
			18: return 23'd14;
			19: return 23'd7;
			20: return 23'd4;
			21: return 23'd2;
			22: return 23'd1;
			default: return 23'd0;
		endcase
	endfunction

endpackage

>>> rtl/gcrf_point_if.sv
interface gcrf_point_if;
	import gcrf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [LAT_W-1:0]  point_lat;
	logic signed [LON_W-1:0]  point_lon;
	logic                     is_last;

	modport source (output valid, point_lat, point_lon, is_last, input ready);
	modport sink   (input valid, point_lat, point_lon, is_last, output ready);
endinterface

>>> rtl/gcrf_result_if.sv
interface gcrf_result_if;
	import gcrf_pkg::*;
	logic               valid;
	logic               ready;
	logic [DIST_W-1:0]  distance;
	logic               within_range;
	logic               last_out;

	modport source (output valid, distance, within_range, last_out, input ready);
	modport sink   (input valid, distance, within_range, last_out, output ready);
endinterface

>>> rtl/gcrf_cos.sv
module gcrf_cos (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_vld,
	input  logic                               in_tag,
	input  logic signed [gcrf_pkg::ANG_W-1:0]  ang,
	output logic                               out_vld,
	output logic                               out_tag,
	output logic signed [gcrf_pkg::COS_W-1:0]  cos_q
);
	import gcrf_pkg::*;

	logic [27:0] v;
	logic [24:0] r;
	logic        vld_s1, tag_s1;
	logic [24:0] r_s1;
	logic [24:0] f;
	logic        vld_s2, tag_s2, neg_s2;
	logic signed [24:0] z_s2;

	logic signed [32:0] x_s [0:STEPS];
	logic signed [32:0] y_s [0:STEPS];
	logic signed [24:0] z_s [0:STEPS];
	logic               n_s [0:STEPS];
	logic               t_s [0:STEPS];
	logic               v_s [0:STEPS];

	logic signed [32:0] xc;
	logic               vld_s3, tag_s3;
	logic signed [COS_W-1:0] cos_s3;

	// reduce modulo one turn
	always_comb begin
		v = 28'($signed({{2{ang[ANG_W-1]}}, ang}) + 28'sd47185920);
		if (v[26:0] >= 27'(3 * TURN_Q16))
			r = 25'(v[26:0] - 27'(3 * TURN_Q16));
		else if (v[26:0] >= 27'(2 * TURN_Q16))
			r = 25'(v[26:0] - 27'(2 * TURN_Q16));
		else if (v[26:0] >= TURN_Q16)
			r = 25'(v[26:0] - TURN_Q16);
		else
			r = v[24:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_tag;
			r_s1   <= r;
		end
	end

	// fold into the first quadrant
	always_comb begin
		if ({2'b00, r_s1} > HALF_Q16)
			f = 25'(TURN_Q16 - {2'b00, r_s1});
		else
			f = r_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			neg_s2 <= {2'b00, f} > QUART_Q16;
			if ({2'b00, f} > QUART_Q16)
				z_s2 <= $signed(25'(HALF_Q16 - {2'b00, f}));
			else
				z_s2 <= $signed(f);
		end
	end

	assign x_s[0] = CORDIC_K;
	assign y_s[0] = '0;
	assign z_s[0] = z_s2;
	assign n_s[0] = neg_s2;
	assign t_s[0] = tag_s2;
	assign v_s[0] = vld_s2;

	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [32:0] dx, dy, xn, yn;
		logic signed [24:0] at, zn;

		assign at = $signed({2'b00, atan_q16(i)});
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_comb begin
			if (z_s[i] >= 0) begin
				xn = x_s[i] - dx;
				yn = y_s[i] + dy;
				zn = z_s[i] - at;
			end else begin
				xn = x_s[i] + dx;
				yn = y_s[i] - dy;
				zn = z_s[i] + at;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1] <= xn;
				y_s[i+1] <= yn;
				z_s[i+1] <= zn;
				n_s[i+1] <= n_s[i];
				t_s[i+1] <= t_s[i];
			end
		end
	end

	always_comb begin
		if (x_s[STEPS] < 0)
			xc = '0;
		else if (x_s[STEPS] > Q_ONE)
			xc = Q_ONE;
		else
			xc = x_s[STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= v_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= t_s[STEPS];
			cos_s3 <= n_s[STEPS] ? COS_W'(-xc) : COS_W'(xc);
		end
	end

	assign out_vld = vld_s3;
	assign out_tag = tag_s3;
	assign cos_q   = cos_s3;
endmodule

>>> rtl/gcrf_isqrt.sv
module gcrf_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic                          in_tag,
	input  logic [gcrf_pkg::HAV_W-1:0]    op,
	output logic                          out_vld,
	output logic                          out_tag,
	output logic [gcrf_pkg::ROOT_W-1:0]   root
);
	import gcrf_pkg::*;

	logic [60:0] rem_s [0:SQRT_STEPS];
	logic [60:0] res_s [0:SQRT_STEPS];
	logic        t_s   [0:SQRT_STEPS];
	logic        v_s   [0:SQRT_STEPS];

	// root of op * 2^30, one result bit a stage
	assign rem_s[0] = {op, 30'b0};
	assign res_s[0] = '0;
	assign t_s[0]   = in_tag;
	assign v_s[0]   = in_vld;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [60:0] BIT = 61'(1) << (60 - 2 * j);
		logic [61:0] t;

		assign t = {1'b0, res_s[j]} + {1'b0, BIT};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j+1] <= 1'b0;
			else if (en)
				v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s[j+1] <= t_s[j];
				if ({1'b0, rem_s[j]} >= t) begin
					rem_s[j+1] <= rem_s[j] - t[60:0];
					res_s[j+1] <= (res_s[j] >> 1) + BIT;
				end else begin
					rem_s[j+1] <= rem_s[j];
					res_s[j+1] <= res_s[j] >> 1;
				end
			end
		end
	end

	assign out_vld = v_s[SQRT_STEPS];
	assign out_tag = t_s[SQRT_STEPS];
	assign root    = res_s[SQRT_STEPS][ROOT_W-1:0];
endmodule

>>> rtl/gcrf_atan.sv
module gcrf_atan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic                          in_tag,
	input  logic [gcrf_pkg::ROOT_W-1:0]   x0,
	input  logic [gcrf_pkg::ROOT_W-1:0]   y0,
	output logic                          out_vld,
	output logic                          out_tag,
	output logic [gcrf_pkg::Z_W-1:0]      z
);
	import gcrf_pkg::*;

	logic signed [32:0] x_s [0:STEPS];
	logic signed [32:0] y_s [0:STEPS];
	logic signed [24:0] z_s [0:STEPS];
	logic               t_s [0:STEPS];
	logic               v_s [0:STEPS];
	logic               vld_s1, tag_s1;
	logic [Z_W-1:0]     z_s1;

	assign x_s[0] = $signed({2'b00, x0});
	assign y_s[0] = $signed({2'b00, y0});
	assign z_s[0] = '0;
	assign t_s[0] = in_tag;
	assign v_s[0] = in_vld;

	for (genvar i = 0; i < STEPS; i++) begin : g_vec
		logic signed [32:0] dx, dy;
		logic signed [24:0] at;

		assign at = $signed({2'b00, atan_q16(i)});
		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s[i+1] <= t_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + dx;
					y_s[i+1] <= y_s[i] - dy;
					z_s[i+1] <= z_s[i] + at;
				end else begin
					x_s[i+1] <= x_s[i] - dx;
					y_s[i+1] <= y_s[i] + dy;
					z_s[i+1] <= z_s[i] - at;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= v_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= t_s[STEPS];
			z_s1   <= (z_s[STEPS] < 0) ? '0 : z_s[STEPS][Z_W-1:0];
		end
	end

	assign out_vld = vld_s1;
	assign out_tag = tag_s1;
	assign z       = z_s1;
endmodule

>>> rtl/great_circle_range_filter.sv
// channel | dir | fields                                   | request
// point   | in  | point_lat, point_lon, is_last            | one point
// result  | out | distance, within_range, last_out         | one distance
// cfg     | in  | cfg_we, cfg_idx, cfg_data                | register write
//
// One point a cycle unless the result stalls; it passes the cosine CORDICs,
// the square roots, the arctangent CORDIC and registers for differences,
// multiplies and scaling. Reset zeroes the valid bits and the config registers.
// A stall at the result freezes every stage at once; nothing is dropped.
module great_circle_range_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gcrf_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [gcrf_pkg::CFG_DATA_W-1:0]     cfg_data,
	gcrf_point_if.sink                          point,
	gcrf_result_if.source                       result
);
	import gcrf_pkg::*;

	function automatic logic [HAV_W-1:0] hav(input logic signed [COS_W-1:0] c);
		logic signed [32:0] d;
		d = Q_ONE - 33'(c);
		return d[31:1];
	endfunction

	logic signed [LAT_W-1:0]  origin_lat_q;
	logic signed [LON_W-1:0]  origin_lon_q;
	logic [RANGE_W-1:0]       range_q;

	logic en;

	logic                     vld_s1, last_s1;
	logic signed [ANG_W-1:0]  olat_s1, plat_s1, dlat_s1, dlon_s1;

	logic                     vld_c, last_c;
	logic signed [COS_W-1:0]  cos_org, cos_pt, cos_dlat, cos_dlon;

	logic                     vld_s2, last_s2;
	logic signed [63:0]       prod_s2;
	logic [HAV_W-1:0]         hlon_s2, hlat_s2;

	logic signed [63:0]       psh;
	logic signed [COS_W-1:0]  p32;
	logic                     vld_s3, last_s3;
	logic signed [63:0]       m_s3;
	logic [HAV_W-1:0]         hlat_s3;

	logic signed [63:0]       msh;
	logic signed [32:0]       sum;
	logic [HAV_W-1:0]         a;
	logic                     vld_s4, last_s4;
	logic [HAV_W-1:0]         a_s4, b_s4;

	logic                     vld_r, last_r;
	logic [ROOT_W-1:0]        s_root, q_root;

	logic                     vld_z, last_z;
	logic [Z_W-1:0]           z;

	logic                     vld_s5, last_s5;
	logic [46:0]              sc_s5;

	logic [47:0]              rnd;
	logic [22:0]              raw;
	logic                     vld_s6, last_s6, within_s6;
	logic [DIST_W-1:0]        dist_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_lat_q <= '0;
			origin_lon_q <= '0;
			range_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ORIGIN_LAT:  origin_lat_q <= $signed(cfg_data[LAT_W-1:0]);
				CFG_ORIGIN_LON:  origin_lon_q <= $signed(cfg_data[LON_W-1:0]);
				CFG_RANGE_MILES: range_q      <= cfg_data[RANGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign en          = !vld_s6 || result.ready;
	assign point.ready = en;

	// angles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= point.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= point.is_last;
			olat_s1 <= ANG_W'(origin_lat_q);
			plat_s1 <= ANG_W'(point.point_lat);
			dlat_s1 <= ANG_W'(point.point_lat) - ANG_W'(origin_lat_q);
			dlon_s1 <= ANG_W'(point.point_lon) - ANG_W'(origin_lon_q);
		end
	end

	gcrf_cos u_cos_org (
		.clk, .arst_n, .en,
		.in_vld(vld_s1), .in_tag(last_s1), .ang(olat_s1),
		.out_vld(vld_c), .out_tag(last_c), .cos_q(cos_org)
	);

	gcrf_cos u_cos_pt (
		.clk, .arst_n, .en,
		.in_vld(vld_s1), .in_tag(last_s1), .ang(plat_s1),
		.out_vld(), .out_tag(), .cos_q(cos_pt)
	);

	gcrf_cos u_cos_dlat (
		.clk, .arst_n, .en,
		.in_vld(vld_s1), .in_tag(last_s1), .ang(dlat_s1),
		.out_vld(), .out_tag(), .cos_q(cos_dlat)
	);

	gcrf_cos u_cos_dlon (
		.clk, .arst_n, .en,
		.in_vld(vld_s1), .in_tag(last_s1), .ang(dlon_s1),
		.out_vld(), .out_tag(), .cos_q(cos_dlon)
	);

	// cos lat1 * cos lat2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= vld_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s2 <= last_c;
			prod_s2 <= cos_org * cos_pt;
			hlon_s2 <= hav(cos_dlon);
			hlat_s2 <= hav(cos_dlat);
		end
	end

	assign psh = prod_s2 >>> 30;
	assign p32 = $signed(psh[COS_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s3 <= last_s2;
			m_s3    <= p32 * $signed({1'b0, hlon_s2});
			hlat_s3 <= hlat_s2;
		end
	end

	// a, clamped to the unit interval
	always_comb begin
		msh = m_s3 >>> 30;
		sum = $signed({msh[31], msh[31:0]}) + $signed({2'b00, hlat_s3});
		if (sum < 0)
			a = '0;
		else if (sum > Q_ONE)
			a = HAV_W'(Q_ONE);
		else
			a = sum[HAV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s4 <= last_s3;
			a_s4    <= a;
			b_s4    <= HAV_W'(Q_ONE) - a;
		end
	end

	gcrf_isqrt u_sqrt_s (
		.clk, .arst_n, .en,
		.in_vld(vld_s4), .in_tag(last_s4), .op(a_s4),
		.out_vld(vld_r), .out_tag(last_r), .root(s_root)
	);

	gcrf_isqrt u_sqrt_q (
		.clk, .arst_n, .en,
		.in_vld(vld_s4), .in_tag(last_s4), .op(b_s4),
		.out_vld(), .out_tag(), .root(q_root)
	);

	gcrf_atan u_atan (
		.clk, .arst_n, .en,
		.in_vld(vld_r), .in_tag(last_r), .x0(q_root), .y0(s_root),
		.out_vld(vld_z), .out_tag(last_z), .z(z)
	);

	// scale to 1/256 mile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s5 <= 1'b0;
		else if (en)
			vld_s5 <= vld_z;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s5 <= last_z;
			sc_s5   <= 47'(z) * 47'(DIST_SCALE);
		end
	end

	assign rnd = {1'b0, sc_s5} + 48'(24'h800000);
	assign raw = rnd[46:24];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s6 <= 1'b0;
		else if (en)
			vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_s6   <= last_s5;
			dist_s6   <= (raw > 23'(DIST_MAX)) ? DIST_MAX : raw[DIST_W-1:0];
			within_s6 <= raw <= 23'({range_q, 8'b0});
		end
	end

	assign result.valid        = vld_s6;
	assign result.distance     = dist_s6;
	assign result.within_range = within_s6;
	assign result.last_out     = last_s6;
endmodule
